>>> rtl/rcd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcd_pkg
// Shared types, constants and the digit-to-ASCII mapping for the radix
// conversion digits unit.
// ----------------------------------------------------------------------------
package rcd_pkg;

  localparam int MAX_DIGITS    = 32;
  localparam int VALUE_BITS    = 31;

  localparam int VALUE_W       = 32;
  localparam int BASE_W        = 6;
  localparam int CHAR_W        = 7;
  localparam int STATUS_W      = 2;

  localparam int S_DATA_W      = ((VALUE_W + BASE_W + 7) / 8) * 8;
  localparam int M_DATA_W      = ((CHAR_W + 7) / 8) * 8;

  localparam int MIN_RADIX     = 2;
  localparam int DECIMAL_LIMIT = 10;
  localparam int ASCII_ZERO    = 48;
  localparam int ASCII_UPPER_A = 65;

  localparam int DIG_W         = $clog2(MAX_DIGITS);
  localparam int CNT_W         = $clog2(MAX_DIGITS + 1);

  localparam int DIV_BITS_PER_STEP = 4;
  localparam int DIV_STEPS     = (VALUE_BITS + DIV_BITS_PER_STEP - 1) / DIV_BITS_PER_STEP;
  localparam int DIV_W         = DIV_STEPS * DIV_BITS_PER_STEP;
  localparam int STEP_W        = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;
  localparam int REM_W         = BASE_W + 1;

  localparam int QUEUE_DEPTH   = 2;
  localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_BAD_BASE = 2'd1,
    ST_EMPTY    = 2'd2
  } status_t;

  typedef struct packed {
    status_t               kind;
    logic [VALUE_BITS-1:0] mag;
    logic [BASE_W-1:0]     base;
  } req_t;

  function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [BASE_W-1:0] d);
    logic [CHAR_W-1:0] ch;
    if (d < BASE_W'(DECIMAL_LIMIT)) begin
      ch = CHAR_W'(ASCII_ZERO) + CHAR_W'(d);
    end else begin
      ch = CHAR_W'(d) - CHAR_W'(DECIMAL_LIMIT) + CHAR_W'(ASCII_UPPER_A);
    end
    return ch;
  endfunction

endpackage

>>> rtl/rcd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcd_front
// Accepts conversion requests, sorts them into bad base, no digits or
// convert, and holds them in a short queue for the back end.
// ----------------------------------------------------------------------------
module rcd_front
  import rcd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [S_DATA_W-1:0] s_tdata,
  output logic                q_valid,
  input  logic                q_ready,
  output req_t                q_data
);

  req_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] fill;
  req_t              incoming;
  logic              push;
  logic              pop;

  logic [VALUE_W-1:0] in_value;
  logic [BASE_W-1:0]  in_base;

  assign in_value = s_tdata[VALUE_W-1:0];
  assign in_base  = s_tdata[VALUE_W+BASE_W-1:VALUE_W];

  always_comb begin
    incoming.mag  = in_value[VALUE_BITS-1:0];
    incoming.base = in_base;
    if (in_base < BASE_W'(MIN_RADIX)) begin
      incoming.kind = ST_BAD_BASE;
    end else if (in_value == '0 || in_value[VALUE_W-1]) begin
      incoming.kind = ST_EMPTY;
    end else begin
      incoming.kind = ST_OK;
    end
  end

  assign s_tready = (fill != QCNT_W'(QUEUE_DEPTH));
  assign q_valid  = (fill != '0);
  assign q_data   = entries[rd_ptr];
  assign push     = s_tvalid && s_tready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + QCNT_W'(1);
      end else if (pop && !push) begin
        fill <= fill - QCNT_W'(1);
      end
    end
  end

endmodule

>>> rtl/rcd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcd_back
// Repeated division by the radix (four quotient bits a cycle), a LIFO
// digit store, and the pop-and-emit sequence into the output register.
// ----------------------------------------------------------------------------
module rcd_back
  import rcd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  output logic                q_ready,
  input  req_t                q_data,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [M_DATA_W-1:0] m_tdata,
  output logic [STATUS_W-1:0] m_tuser,
  output logic                m_tlast
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_READ,
    S_SEND,
    S_REPORT
  } state_t;

  state_t             state;
  status_t            kind;
  logic [DIV_W-1:0]   work;
  logic [BASE_W-1:0]  rem;
  logic [BASE_W-1:0]  radix;
  logic [STEP_W-1:0]  step;
  logic [CNT_W-1:0]   stack_count;
  logic [BASE_W-1:0]  digit_stack [MAX_DIGITS];
  logic [BASE_W-1:0]  rd_digit;
  logic [CHAR_W-1:0]  out_char;

  logic [DIV_W-1:0]   work_next;
  logic [BASE_W-1:0]  rem_next;
  logic               div_done;
  logic               push;
  logic               pop_rd;
  logic               out_free;
  logic               out_load;

  // restoring division, several quotient bits per cycle
  always_comb begin
    logic [REM_W-1:0] r;
    logic [DIV_W-1:0] w;
    r = {1'b0, rem};
    w = work;
    for (int i = 0; i < DIV_BITS_PER_STEP; i++) begin
      r = {r[REM_W-2:0], w[DIV_W-1]};
      w = {w[DIV_W-2:0], 1'b0};
      if (r >= {1'b0, radix}) begin
        r    = r - {1'b0, radix};
        w[0] = 1'b1;
      end
    end
    work_next = w;
    rem_next  = r[BASE_W-1:0];
  end

  assign div_done = (state == S_DIV) && (step == STEP_W'(DIV_STEPS - 1));
  assign push     = div_done && (stack_count < CNT_W'(MAX_DIGITS));
  assign pop_rd   = (state == S_READ);
  assign out_free = !m_tvalid || m_tready;
  assign out_load = out_free && ((state == S_SEND) || (state == S_REPORT));
  assign q_ready  = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (push) begin
      digit_stack[stack_count[DIG_W-1:0]] <= rem_next;
    end
    if (pop_rd) begin
      rd_digit <= digit_stack[DIG_W'(stack_count - CNT_W'(1))];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      kind        <= ST_OK;
      work        <= '0;
      rem         <= '0;
      radix       <= '0;
      step        <= '0;
      stack_count <= '0;
      m_tvalid    <= 1'b0;
      out_char    <= '0;
      m_tuser     <= '0;
      m_tlast     <= 1'b0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            kind        <= q_data.kind;
            radix       <= q_data.base;
            work        <= {{(DIV_W - VALUE_BITS){1'b0}}, q_data.mag};
            rem         <= '0;
            step        <= '0;
            stack_count <= '0;
            state       <= (q_data.kind == ST_OK) ? S_DIV : S_REPORT;
          end
        end
        S_DIV: begin
          work <= work_next;
          if (div_done) begin
            rem  <= '0;
            step <= '0;
            if (push) begin
              stack_count <= stack_count + CNT_W'(1);
            end
            if (work_next == '0) begin
              state <= S_READ;
            end
          end else begin
            rem  <= rem_next;
            step <= step + STEP_W'(1);
          end
        end
        S_READ: begin
          stack_count <= stack_count - CNT_W'(1);
          state       <= S_SEND;
        end
        S_SEND: begin
          if (out_free) begin
            out_char <= digit_to_ascii(rd_digit);
            m_tuser  <= ST_OK;
            m_tlast  <= (stack_count == '0);
            state    <= (stack_count == '0) ? S_IDLE : S_READ;
          end
        end
        S_REPORT: begin
          if (out_free) begin
            out_char <= '0;
            m_tuser  <= kind;
            m_tlast  <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign m_tdata = {{(M_DATA_W - CHAR_W){1'b0}}, out_char};

endmodule

>>> rtl/radix_conversion_digits_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix_conversion_digits_unit
// Converts a signed value to ASCII digits in a given base, most
// significant digit first, with a status code for bad bases and values
// that give no digits.
// ----------------------------------------------------------------------------
//  channel  dir  tdata (low bit up)          tuser    tlast
//  s_*      in   value[31:0], base[37:32]    -        -
//  m_*      out  digit_char[6:0]             status   last of a request
//
// a conversion is taken in from idle, the divider then makes every digit
// (four quotient bits a cycle over 31 value bits), then the read and send
// states pop and emit each digit; a rejected request goes to report state
// the front queue holds two requests, so input is still taken during a
// conversion and while a result waits in the output register, until it fills
// rst is synchronous and clears all control state; no clearing pass
// ----------------------------------------------------------------------------
module radix_conversion_digits_unit
  import rcd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [S_DATA_W-1:0] s_tdata,   // value, base, zero fill
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [M_DATA_W-1:0] m_tdata,   // digit_char, zero fill
  output logic [STATUS_W-1:0] m_tuser,   // status
  output logic                m_tlast
);

  logic q_valid;
  logic q_ready;
  req_t q_data;

  rcd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_data   (q_data)
  );

  rcd_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_data   (q_data),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Regression for radix_conversion_digits_unit: a table of directed requests
// followed by random requests, with random gaps on both streams. Typed rows
// queue their expected result, other requests go through a local predictor;
// each emitted digit is compared against the oldest pending expectation.
// ----------------------------------------------------------------------------
module tb;
  import rcd_pkg::*;

  localparam int RANDOM_REQUESTS = 310;
  localparam int IDLE_LIMIT      = 4000;
  localparam int SETTLE_CYCLES   = 400;
  localparam int DIRECTED_ROWS   = 20;

  typedef struct {
    logic [CHAR_W-1:0] ch;
    status_t           st;
    logic              last;
  } digit_res_t;

  typedef struct {
    logic [VALUE_W-1:0] value;
    logic [BASE_W-1:0]  base;
    bit                 typed;
    logic [CHAR_W-1:0]  ch;
    status_t            st;
    logic               last;
  } conv_row_t;

  logic                clk;
  logic                rst;
  logic                s_tvalid;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata;   // value, base, zero fill
  logic                m_tvalid;
  logic                m_tready;
  logic [M_DATA_W-1:0] m_tdata;   // digit_char, zero fill
  logic [STATUS_W-1:0] m_tuser;   // status
  logic                m_tlast;

  digit_res_t digits_due[$];
  int         mismatches;
  bit         steady_tx;

  conv_row_t dir_rows[DIRECTED_ROWS] = '{
    '{32'd5,          6'd0,  1'b1, 7'd0,  ST_BAD_BASE, 1'b1},
    '{32'hFFFF_FFFF,  6'd1,  1'b1, 7'd0,  ST_BAD_BASE, 1'b1},
    '{32'd0,          6'd0,  1'b1, 7'd0,  ST_BAD_BASE, 1'b1},
    '{32'h8000_0000,  6'd1,  1'b1, 7'd0,  ST_BAD_BASE, 1'b1},
    '{32'd0,          6'd10, 1'b1, 7'd0,  ST_EMPTY,    1'b1},
    '{32'hFFFF_FFFF,  6'd10, 1'b1, 7'd0,  ST_EMPTY,    1'b1},
    '{32'h8000_0000,  6'd2,  1'b1, 7'd0,  ST_EMPTY,    1'b1},
    '{32'd0,          6'd36, 1'b1, 7'd0,  ST_EMPTY,    1'b1},
    '{32'd1,          6'd2,  1'b1, 7'h31, ST_OK,       1'b1},
    '{32'd9,          6'd10, 1'b1, 7'h39, ST_OK,       1'b1},
    '{32'd35,         6'd36, 1'b1, 7'h5A, ST_OK,       1'b1},
    '{32'd10,         6'd16, 1'b1, 7'h41, ST_OK,       1'b1},
    '{32'd1,          6'd36, 1'b1, 7'h31, ST_OK,       1'b1},
    '{32'h7FFF_FFFF,  6'd2,  1'b0, 7'd0,  ST_OK,       1'b0},
    '{32'h7FFF_FFFF,  6'd36, 1'b0, 7'd0,  ST_OK,       1'b0},
    '{32'h7FFF_FFFF,  6'd10, 1'b0, 7'd0,  ST_OK,       1'b0},
    '{32'd36,         6'd36, 1'b0, 7'd0,  ST_OK,       1'b0},
    '{32'd32,         6'd32, 1'b0, 7'd0,  ST_OK,       1'b0},
    '{32'd12345,      6'd10, 1'b0, 7'd0,  ST_OK,       1'b0},
    '{32'h4000_0000,  6'd3,  1'b0, 7'd0,  ST_OK,       1'b0}
  };

  radix_conversion_digits_unit uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [CHAR_W-1:0] digit_char_of(input logic [BASE_W-1:0] d);
    if (d < BASE_W'(DECIMAL_LIMIT)) return CHAR_W'(ASCII_ZERO) + CHAR_W'(d);
    return CHAR_W'(d) + CHAR_W'(ASCII_UPPER_A - DECIMAL_LIMIT);
  endfunction

  task automatic predict_digits(input logic [VALUE_W-1:0] value, input logic [BASE_W-1:0] base);
    logic [VALUE_BITS-1:0] quo;
    logic [BASE_W-1:0]     stack[MAX_DIGITS];
    int                    depth;
    digit_res_t            res;
    if (base < BASE_W'(MIN_RADIX)) begin
      res = '{ch: '0, st: ST_BAD_BASE, last: 1'b1};
      digits_due.push_back(res);
    end else if (value == '0 || value[VALUE_W-1]) begin
      res = '{ch: '0, st: ST_EMPTY, last: 1'b1};
      digits_due.push_back(res);
    end else begin
      quo   = value[VALUE_BITS-1:0];
      depth = 0;
      while (quo != '0) begin
        if (depth < MAX_DIGITS) begin
          stack[depth] = BASE_W'(quo % base);
          depth++;
        end
        quo = quo / base;
      end
      while (depth > 0) begin
        depth--;
        res = '{ch: digit_char_of(stack[depth]), st: ST_OK, last: (depth == 0)};
        digits_due.push_back(res);
      end
    end
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  task automatic send_request(input logic [VALUE_W-1:0] value, input logic [BASE_W-1:0] base,
                              input bit typed, input digit_res_t typed_res);
    int gap;
    gap = (steady_tx || $urandom_range(0, 99) < 45) ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= {{(S_DATA_W - VALUE_W - BASE_W){1'b0}}, base, value};
    forever begin
      @(posedge clk);
      if (s_tready) break;
    end
    if (typed) digits_due.push_back(typed_res);
    else predict_digits(value, base);
  endtask

  task automatic drain_pending();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (digits_due.size() != 0) @(posedge clk);
  endtask

  // random result-side back pressure with occasional steady stretches
  initial begin
    int  stall_left;
    int  run_left;
    bit  steady_rx;
    m_tready   = 1'b0;
    stall_left = 0;
    run_left   = 0;
    steady_rx  = 1'b0;
    forever begin
      @(negedge clk);
      if (run_left == 0) begin
        steady_rx = ($urandom_range(0, 3) == 0);
        run_left  = $urandom_range(20, 200);
      end else begin
        run_left--;
      end
      if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else begin
        m_tready <= 1'b1;
        if (!steady_rx && $urandom_range(0, 99) < 30) stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk) begin : check_digits
    digit_res_t due;
    if (!rst && m_tvalid && m_tready) begin
      if (digits_due.size() == 0) begin
        report_mismatch("digit with nothing pending", int'(m_tdata), 0);
      end else begin
        due = digits_due.pop_front();
        if (m_tdata !== {{(M_DATA_W - CHAR_W){1'b0}}, due.ch})
          report_mismatch("digit_char", int'(m_tdata), int'(due.ch));
        if (m_tuser !== due.st)
          report_mismatch("status", int'(m_tuser), int'(due.st));
        if (m_tlast !== due.last)
          report_mismatch("last", int'(m_tlast), int'(due.last));
      end
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("radix_conversion_digits_unit regression: fail");
    $finish;
  end

  initial begin
    digit_res_t         row_res;
    logic [VALUE_W-1:0] value;
    logic [BASE_W-1:0]  base;
    int                 r;
    int                 width;
    int                 steady_left;
    mismatches  = 0;
    steady_tx   = 1'b0;
    steady_left = 0;
    rst         = 1'b1;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (dir_rows[i]) begin
      row_res = '{ch: dir_rows[i].ch, st: dir_rows[i].st, last: dir_rows[i].last};
      send_request(dir_rows[i].value, dir_rows[i].base, dir_rows[i].typed, row_res);
    end
    drain_pending();

    row_res = '{ch: '0, st: ST_OK, last: 1'b0};
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (steady_left == 0) begin
        steady_tx   = ($urandom_range(0, 3) == 0);
        steady_left = $urandom_range(10, 40);
      end else begin
        steady_left--;
      end
      if (n == RANDOM_REQUESTS / 2) drain_pending();

      r = $urandom_range(0, 99);
      if (r < 8) base = BASE_W'($urandom_range(0, 1));
      else if (r < 14) base = ($urandom_range(0, 1) == 0) ? BASE_W'(MIN_RADIX) : 6'd36;
      else base = BASE_W'($urandom_range(MIN_RADIX, 36));

      r = $urandom_range(0, 99);
      if (r < 6) begin
        value = '0;
      end else if (r < 14) begin
        value = $urandom | 32'h8000_0000;
      end else if (r < 18) begin
        value = 32'h7FFF_FFFF;
      end else begin
        width = $urandom_range(1, VALUE_BITS);
        value = $urandom & VALUE_W'((64'd1 << width) - 1);
      end
      send_request(value, base, 1'b0, row_res);
    end
    drain_pending();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("radix_conversion_digits_unit regression: pass");
    end else begin
      $display("radix_conversion_digits_unit regression: fail");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/rcd_pkg.sv
rtl/rcd_front.sv
rtl/rcd_back.sv
rtl/radix_conversion_digits_unit.sv
tb/sv/tb.sv
